[rtl/core/pibc_pkg.sv]
// pibc_pkg: widths, register indexes and reset values of the PI regulator.
// Used by pibc_mul, pi_regulator_back_calc and pibc_checker.
`timescale 1ns / 1ps

package pibc_pkg;

    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 17;
    localparam int ACC_W   = 32;
    localparam int OUT_W   = 16;
    localparam int SHIFT_W = 5;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 32;

    // fixed right shift of the integral accumulator into the output sum
    localparam int KI_SHIFT = 14;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_KP_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_KS_GAIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_INT_UPPER = 3'd3;
    localparam logic [IDX_W-1:0] REG_INT_LOWER = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_UPPER = 3'd5;
    localparam logic [IDX_W-1:0] REG_OUT_LOWER = 3'd6;
    localparam logic [IDX_W-1:0] REG_KP_SHIFT  = 3'd7;

    // reset values
    localparam logic [GAIN_W-1:0]  KP_GAIN_RST   = 16'sd16384;
    localparam logic [GAIN_W-1:0]  KI_GAIN_RST   = 16'sd100;
    localparam logic [GAIN_W-1:0]  KS_GAIN_RST   = 16'sd8192;
    localparam logic [ACC_W-1:0]   INT_UPPER_RST = 32'sd536854528;
    localparam logic [ACC_W-1:0]   INT_LOWER_RST = -32'sd536854528;
    localparam logic [OUT_W-1:0]   OUT_UPPER_RST = 16'sd32767;
    localparam logic [OUT_W-1:0]   OUT_LOWER_RST = -16'sd32767;
    localparam logic [SHIFT_W-1:0] KP_SHIFT_RST  = 5'd14;

    // saturated accumulator values on signed overflow
    localparam logic [ACC_W-1:0] ACC_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_NEG_SAT = 32'h8000_0001;

endpackage

[rtl/core/pibc_mul.sv]
// pibc_mul: serial shift-add multiplier, one multiplier bit per cycle.
// Signed operands, product wrapped to the multiplicand width. Uses pibc_pkg.
`timescale 1ns / 1ps

module pibc_mul #(
    parameter int MCAND_W  = pibc_pkg::ACC_W,
    parameter int MPLIER_W = pibc_pkg::GAIN_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MCAND_W-1:0]  mcand,
    input  logic [MPLIER_W-1:0] mplier,
    output logic                done,
    output logic [MCAND_W-1:0]  product
);

    localparam int CNT_W = (MPLIER_W > 1) ? $clog2(MPLIER_W) : 1;

    logic [MCAND_W-1:0]  mcand_reg;
    logic [MPLIER_W-1:0] mplier_reg;
    logic [MCAND_W-1:0]  prod_reg;
    logic [MCAND_W-1:0]  prod_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                last_bit;

    assign last_bit = (cnt_reg == CNT_W'(MPLIER_W - 1));

    // top multiplier bit carries negative weight
    always_comb
    begin
        prod_next = prod_reg;
        if (mplier_reg[0])
        begin
            if (last_bit)
                prod_next = prod_reg - mcand_reg;
            else
                prod_next = prod_reg + mcand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            mcand_reg  <= {mcand_reg[MCAND_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MPLIER_W-1:1]};
            prod_reg   <= prod_next;
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

[rtl/core/pi_regulator_back_calc.sv]
// pi_regulator_back_calc: PI regulator with back-calculation anti-windup.
// Uses pibc_pkg and pibc_mul (shared serial multiplier).
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------
//  in      | in_valid/in_stall   | func, error, integral_preset
//  out     | out_valid/out_stall | drive, clamped
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// A preset word only loads the accumulator. A compute word runs the P and I
// products, saturation, integral clamp, output sum and clamp, and on a clamp
// the back-calculation product; a zero ki_gain skips the I steps. Each product
// runs on the one serial multiplier (start, 16 bit steps, hand-off).
// Reset clears the accumulator and loads the register defaults.
// A result waiting on out_stall does not block the next accept; a second
// result waits in its final state until the output register frees.
`timescale 1ns / 1ps

module pi_regulator_back_calc #(
    parameter int KI_SHIFT = pibc_pkg::KI_SHIFT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic signed [pibc_pkg::ERR_W-1:0]   error,
    input  logic signed [pibc_pkg::ACC_W-1:0]   integral_preset,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pibc_pkg::OUT_W-1:0]   drive,
    output logic                                clamped,
    input  logic                                cfg_we,
    input  logic [pibc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [pibc_pkg::CFG_W-1:0]          cfg_data
);

    localparam int ACC_W  = pibc_pkg::ACC_W;
    localparam int GAIN_W = pibc_pkg::GAIN_W;
    localparam int OUT_W  = pibc_pkg::OUT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I,
        S_SAT,
        S_ICLAMP,
        S_OSUM,
        S_OCLAMP,
        S_MUL_K,
        S_OUT
    } state_t;

    // configuration
    logic signed [GAIN_W-1:0]       kp_gain_reg;
    logic signed [GAIN_W-1:0]       ki_gain_reg;
    logic signed [GAIN_W-1:0]       ks_gain_reg;
    logic signed [ACC_W-1:0]        int_upper_reg;
    logic signed [ACC_W-1:0]        int_lower_reg;
    logic signed [OUT_W-1:0]        out_upper_reg;
    logic signed [OUT_W-1:0]        out_lower_reg;
    logic [pibc_pkg::SHIFT_W-1:0]   kp_shift_reg;

    // datapath
    state_t                   state_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prop_reg;
    logic signed [ACC_W-1:0]  work_reg;
    logic [ACC_W-1:0]         mul_a_reg;
    logic [GAIN_W-1:0]        mul_b_reg;
    logic                     mul_start_reg;
    logic                     mul_done;
    logic [ACC_W-1:0]         mul_prod;
    logic signed [OUT_W-1:0]  res_drive_reg;
    logic                     res_hit_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  drive_reg;
    logic                     clamped_reg;

    logic signed [ACC_W-1:0]  sum_raw;
    logic signed [ACC_W-1:0]  sum_sat;
    logic signed [ACC_W-1:0]  out_hi;
    logic signed [ACC_W-1:0]  out_lo;
    logic signed [ACC_W-1:0]  osum_next;
    logic                     in_take;
    logic                     out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // accumulator plus integral term, saturating on signed overflow
    always_comb
    begin
        sum_raw = acc_reg + work_reg;
        sum_sat = sum_raw;
        if (!acc_reg[ACC_W-1] && !work_reg[ACC_W-1] && sum_raw[ACC_W-1])
            sum_sat = pibc_pkg::ACC_POS_SAT;
        else if (acc_reg[ACC_W-1] && work_reg[ACC_W-1] && !sum_raw[ACC_W-1])
            sum_sat = pibc_pkg::ACC_NEG_SAT;
    end

    assign out_hi    = ACC_W'(out_upper_reg);
    assign out_lo    = ACC_W'(out_lower_reg);
    assign osum_next = (prop_reg >>> kp_shift_reg) + (acc_reg >>> KI_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg   <= pibc_pkg::KP_GAIN_RST;
            ki_gain_reg   <= pibc_pkg::KI_GAIN_RST;
            ks_gain_reg   <= pibc_pkg::KS_GAIN_RST;
            int_upper_reg <= pibc_pkg::INT_UPPER_RST;
            int_lower_reg <= pibc_pkg::INT_LOWER_RST;
            out_upper_reg <= pibc_pkg::OUT_UPPER_RST;
            out_lower_reg <= pibc_pkg::OUT_LOWER_RST;
            kp_shift_reg  <= pibc_pkg::KP_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pibc_pkg::REG_KP_GAIN:   kp_gain_reg   <= cfg_data[GAIN_W-1:0];
                pibc_pkg::REG_KI_GAIN:   ki_gain_reg   <= cfg_data[GAIN_W-1:0];
                pibc_pkg::REG_KS_GAIN:   ks_gain_reg   <= cfg_data[GAIN_W-1:0];
                pibc_pkg::REG_INT_UPPER: int_upper_reg <= cfg_data[ACC_W-1:0];
                pibc_pkg::REG_INT_LOWER: int_lower_reg <= cfg_data[ACC_W-1:0];
                pibc_pkg::REG_OUT_UPPER: out_upper_reg <= cfg_data[OUT_W-1:0];
                pibc_pkg::REG_OUT_LOWER: out_lower_reg <= cfg_data[OUT_W-1:0];
                pibc_pkg::REG_KP_SHIFT:
                    kp_shift_reg <= cfg_data[pibc_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            prop_reg      <= '0;
            work_reg      <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_start_reg <= 1'b0;
            res_drive_reg <= '0;
            res_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            clamped_reg   <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        if (func)
                            acc_reg <= integral_preset;
                        else
                        begin
                            mul_a_reg     <= ACC_W'(error);
                            mul_b_reg     <= kp_gain_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL_P;
                        end
                    end
                end
                S_MUL_P:
                begin
                    if (mul_done)
                    begin
                        prop_reg <= mul_prod;
                        if (ki_gain_reg == '0)
                        begin
                            acc_reg   <= '0;
                            state_reg <= S_OSUM;
                        end
                        else
                        begin
                            mul_b_reg     <= ki_gain_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL_I;
                        end
                    end
                end
                S_MUL_I:
                begin
                    if (mul_done)
                    begin
                        work_reg  <= mul_prod;
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    work_reg  <= sum_sat;
                    state_reg <= S_ICLAMP;
                end
                S_ICLAMP:
                begin
                    // upper limit tested first
                    if (work_reg > int_upper_reg)
                        acc_reg <= int_upper_reg;
                    else if (work_reg < int_lower_reg)
                        acc_reg <= int_lower_reg;
                    else
                        acc_reg <= work_reg;
                    state_reg <= S_OSUM;
                end
                S_OSUM:
                begin
                    work_reg  <= osum_next;
                    state_reg <= S_OCLAMP;
                end
                S_OCLAMP:
                begin
                    if (work_reg > out_hi)
                    begin
                        res_drive_reg <= out_upper_reg;
                        res_hit_reg   <= 1'b1;
                        mul_a_reg     <= out_hi - work_reg;
                        mul_b_reg     <= ks_gain_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_K;
                    end
                    else if (work_reg < out_lo)
                    begin
                        res_drive_reg <= out_lower_reg;
                        res_hit_reg   <= 1'b1;
                        mul_a_reg     <= out_lo - work_reg;
                        mul_b_reg     <= ks_gain_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_K;
                    end
                    else
                    begin
                        // no excess, so no back-calculation pass
                        res_drive_reg <= work_reg[OUT_W-1:0];
                        res_hit_reg   <= 1'b0;
                        state_reg     <= S_OUT;
                    end
                end
                S_MUL_K:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_reg + mul_prod;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        drive_reg     <= res_drive_reg;
                        clamped_reg   <= res_hit_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    pibc_mul #(
        .MCAND_W  (ACC_W),
        .MPLIER_W (GAIN_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .mcand   (mul_a_reg),
        .mplier  (mul_b_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

endmodule

[rtl/core/pibc_checker.sv]
// pibc_props: port-level assertions for pi_regulator_back_calc, with bind.
// Uses pibc_pkg for port widths.
`timescale 1ns / 1ps

module pibc_props (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                func,
    input logic signed [pibc_pkg::ERR_W-1:0]   error,
    input logic signed [pibc_pkg::ACC_W-1:0]   integral_preset,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [pibc_pkg::OUT_W-1:0]   drive,
    input logic                                clamped,
    input logic                                cfg_we,
    input logic [pibc_pkg::IDX_W-1:0]          cfg_index,
    input logic [pibc_pkg::CFG_W-1:0]          cfg_data
);

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive) && $stable(clamped))
        else $error("result word changed while stalled");

    // a compute word keeps the input side busy
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !func |=> in_stall)
        else $error("input taken again during a compute word");

    // a preset word leaves the input side free on the next cycle
    a_preset_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func |=> !in_stall)
        else $error("preset word held the input side");

    // a new result only comes out of a compute in progress
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without a compute in progress");

endmodule

bind pi_regulator_back_calc pibc_props u_pibc_props (.*);

[dv/pibc_tb_pkg.sv]
// pibc_tb_pkg: input function codes, field extremes and the result word type
// shared by the regulator checker and the testbench top. Depends on pibc_pkg.
`timescale 1ns / 1ps

package pibc_tb_pkg;

    import pibc_pkg::*;

    typedef enum logic {
        FUNC_STEP   = 1'b0,
        FUNC_PRESET = 1'b1
    } reg_func_e;

    localparam logic signed [ERR_W-1:0]  ERR_MIN  = 17'h1_0000;
    localparam logic signed [ERR_W-1:0]  ERR_MAX  = 17'h0_FFFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 16'h8000;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 16'h7FFF;
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = 32'h8000_0000;
    localparam logic signed [ACC_W-1:0]  ACC_MAX  = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [OUT_W-1:0] drive;
        logic                    clamped;
    } drive_word_t;

endpackage

[dv/pibc_checker.sv]
// pibc_checker: watches the config port and both word channels of the PI
// regulator, predicts each drive word and compares it in order.
// Depends on pibc_pkg and pibc_tb_pkg.
`timescale 1ns / 1ps

module pibc_checker
    import pibc_pkg::*;
    import pibc_tb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       func,
    input  logic signed [ERR_W-1:0]    error,
    input  logic signed [ACC_W-1:0]    integral_preset,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [OUT_W-1:0]    drive,
    input  logic                       clamped,
    input  logic                       cfg_we,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output int                         mismatches,
    output int                         pending_results
);

    logic signed [GAIN_W-1:0] kp, ki, ks;
    logic signed [ACC_W-1:0]  int_hi, int_lo;
    logic signed [OUT_W-1:0]  out_hi, out_lo;
    logic [SHIFT_W-1:0]       p_shift;
    logic signed [ACC_W-1:0]  integ;

    drive_word_t drive_queue[$];
    int          mismatch_count = 0;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // one compute word: updates the accumulator copy, returns the drive word
    function automatic drive_word_t regulate_step(input logic signed [ERR_W-1:0] err);
        longint                  prod;
        logic signed [ACC_W-1:0] prop, iterm, sum, osum, excess;
        drive_word_t             res;
        prod = longint'(kp) * longint'(err);
        prop = prod[ACC_W-1:0];
        if (ki == 0)
            integ = '0;
        else
        begin
            prod  = longint'(ki) * longint'(err);
            iterm = prod[ACC_W-1:0];
            sum   = integ + iterm;
            if (sum < 0 && integ > 0 && iterm > 0)
                sum = ACC_POS_SAT;
            else if (sum >= 0 && integ < 0 && iterm < 0)
                sum = ACC_NEG_SAT;
            // upper limit wins when the limits are inverted
            if (sum > int_hi)
                sum = int_hi;
            else if (sum < int_lo)
                sum = int_lo;
            integ = sum;
        end
        osum        = (prop >>> p_shift) + (integ >>> KI_SHIFT);
        excess      = '0;
        res.clamped = 1'b0;
        res.drive   = osum[OUT_W-1:0];
        if (osum > out_hi)
        begin
            excess      = out_hi - osum;
            res.drive   = out_hi;
            res.clamped = 1'b1;
        end
        else if (osum < out_lo)
        begin
            excess      = out_lo - osum;
            res.drive   = out_lo;
            res.clamped = 1'b1;
        end
        integ = integ + excess * ks;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_word_t want;
        if (!rst_n)
        begin
            kp      = KP_GAIN_RST;
            ki      = KI_GAIN_RST;
            ks      = KS_GAIN_RST;
            int_hi  = INT_UPPER_RST;
            int_lo  = INT_LOWER_RST;
            out_hi  = OUT_UPPER_RST;
            out_lo  = OUT_LOWER_RST;
            p_shift = KP_SHIFT_RST;
            integ   = '0;
            drive_queue.delete();
            pending_results <= 0;
            mismatches      <= mismatch_count;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KP_GAIN:   kp      = cfg_data[GAIN_W-1:0];
                    REG_KI_GAIN:   ki      = cfg_data[GAIN_W-1:0];
                    REG_KS_GAIN:   ks      = cfg_data[GAIN_W-1:0];
                    REG_INT_UPPER: int_hi  = cfg_data[ACC_W-1:0];
                    REG_INT_LOWER: int_lo  = cfg_data[ACC_W-1:0];
                    REG_OUT_UPPER: out_hi  = cfg_data[OUT_W-1:0];
                    REG_OUT_LOWER: out_lo  = cfg_data[OUT_W-1:0];
                    REG_KP_SHIFT:  p_shift = cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (drive_queue.size() == 0)
                    report_mismatch($sformatf("drive word %0d with none predicted", drive));
                else
                begin
                    want = drive_queue.pop_front();
                    if (drive !== want.drive)
                        report_mismatch($sformatf("drive %0d, predicted %0d",
                                                  drive, want.drive));
                    if (clamped !== want.clamped)
                        report_mismatch($sformatf("clamped %b, predicted %b",
                                                  clamped, want.clamped));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_PRESET)
                    integ = integral_preset;
                else
                    drive_queue.push_back(regulate_step(error));
            end
            pending_results <= drive_queue.size();
            mismatches      <= mismatch_count;
        end
    end

endmodule

[dv/testbench.sv]
// testbench: drives directed and random error/preset words into the PI
// regulator over several register settings with random idling on both sides.
// Depends on pibc_pkg, pibc_tb_pkg, pibc_checker and pi_regulator_back_calc.
`timescale 1ns / 1ps

module testbench;

    import pibc_pkg::*;
    import pibc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 100;   // covers a clamped compute word
    localparam int HOLD_CYCLES = 400;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     func;
    logic signed [ERR_W-1:0]  error;
    logic signed [ACC_W-1:0]  integral_preset;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [OUT_W-1:0]  drive;
    logic                     clamped;
    logic                     cfg_we;
    logic [IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    int                       mismatches;
    int                       pending_results;

    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;
    int cycle_count;

    pi_regulator_back_calc DUT (.*);

    pibc_checker regulator_watch (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or one long hold when asked
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= rx_gaps && ($urandom_range(99) < 23);
        end
    end

    task automatic send_word(input reg_func_e f, input logic signed [ERR_W-1:0] e,
                             input logic [ACC_W-1:0] p);
        while (tx_gaps && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        func            <= f;
        error           <= e;
        integral_preset <= p;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and let every predicted word come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic signed [GAIN_W-1:0] kp,
                                input logic signed [GAIN_W-1:0] ki,
                                input logic signed [GAIN_W-1:0] ks,
                                input logic signed [ACC_W-1:0]  iu,
                                input logic signed [ACC_W-1:0]  il,
                                input logic signed [OUT_W-1:0]  ou,
                                input logic signed [OUT_W-1:0]  ol,
                                input logic [SHIFT_W-1:0]       sh);
        write_reg(REG_KP_GAIN, CFG_W'(kp));
        write_reg(REG_KI_GAIN, CFG_W'(ki));
        write_reg(REG_KS_GAIN, CFG_W'(ks));
        write_reg(REG_INT_UPPER, iu);
        write_reg(REG_INT_LOWER, il);
        write_reg(REG_OUT_UPPER, CFG_W'(ou));
        write_reg(REG_OUT_LOWER, CFG_W'(ol));
        write_reg(REG_KP_SHIFT, CFG_W'(sh));
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [GAIN_W-1:0] wide_gain();
        case ($urandom_range(3))
            0:       return GAIN_MIN;
            1:       return GAIN_MAX;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ACC_W-1:0] wide_acc();
        case ($urandom_range(3))
            0:       return ACC_MIN;
            1:       return ACC_MAX;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [ERR_W-1:0] pick_error();
        logic signed [ERR_W-1:0] e;
        case ($urandom_range(3))
            0: e = ERR_W'($urandom);
            1:
            begin
                e = ERR_W'($urandom_range(4000));
                e = e - 17'sd2000;
            end
            2: e = $urandom_range(1) ? ERR_MAX : ERR_MIN;
            default:
            begin
                e = ERR_W'($urandom_range(40000));
                e = e - 17'sd20000;
            end
        endcase
        return e;
    endfunction

    function automatic logic signed [ACC_W-1:0] pick_preset();
        logic signed [ACC_W-1:0] p;
        case ($urandom_range(2))
            0: p = $urandom;
            1:
            begin
                p = $urandom_range(32'd536870912);
                p = p - 32'sd268435456;
            end
            default: p = $urandom_range(1) ? ACC_MAX : ACC_MIN;
        endcase
        return p;
    endfunction

    // tame settings keep the loop mostly linear; wild ones favor extremes
    task automatic random_settings(input bit tame);
        logic signed [GAIN_W-1:0] kp, ki, ks;
        logic signed [OUT_W-1:0]  ou, ol;
        logic signed [ACC_W-1:0]  iu, il;
        logic [SHIFT_W-1:0]       sh;
        if (tame)
        begin
            kp = GAIN_W'($urandom_range(32767));
            ki = GAIN_W'($urandom_range(4000));
            ki = ki - 16'sd2000;
            if ($urandom_range(7) == 0)
                ki = '0;
            ks = GAIN_W'($urandom_range(16383));
            iu = $urandom_range(600000000);
            il = -iu;
            ou = OUT_W'($urandom_range(32767, 1000));
            ol = -ou;
            sh = SHIFT_W'($urandom_range(18, 8));
        end
        else
        begin
            kp = wide_gain();
            ki = wide_gain();
            ks = wide_gain();
            ou = wide_gain();
            ol = wide_gain();
            iu = wide_acc();
            il = wide_acc();
            case ($urandom_range(2))
                0:       sh = '0;
                1:       sh = '1;
                default: sh = SHIFT_W'($urandom);
            endcase
        end
        program_regs(kp, ki, ks, iu, il, ou, ol, sh);
    endtask

    task automatic run_phase(input int n_words, input int pause_at, input int hold_at);
        for (int k = 0; k < n_words; k++)
        begin
            if (k == hold_at)
                hold_request = 1'b1;
            if (k == pause_at)
                drain();
            if ($urandom_range(99) < 12)
                send_word(FUNC_PRESET, pick_error(), pick_preset());
            else
                send_word(FUNC_STEP, pick_error(), $urandom);
        end
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        in_valid        <= 1'b0;
        func            <= FUNC_STEP;
        error           <= '0;
        integral_preset <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_KP_GAIN;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        send_word(FUNC_STEP, '0, $urandom);
        send_word(FUNC_STEP, ERR_MAX, $urandom);
        send_word(FUNC_STEP, ERR_MIN, $urandom);
        send_word(FUNC_PRESET, ERR_MAX, ACC_MAX);
        send_word(FUNC_STEP, 17'sd1, $urandom);
        send_word(FUNC_PRESET, ERR_MIN, ACC_MIN);
        send_word(FUNC_STEP, -17'sd1, $urandom);

        // full-range limits, shift 0: accumulator saturates both ways
        drain();
        program_regs(GAIN_MAX, GAIN_MAX, GAIN_MIN, ACC_MAX, ACC_MIN,
                     GAIN_MAX, GAIN_MIN, 5'd0);
        send_word(FUNC_PRESET, '0, 32'h7FFF_FFF0);
        send_word(FUNC_STEP, ERR_MAX, $urandom);
        send_word(FUNC_PRESET, '0, 32'h8000_0005);
        send_word(FUNC_STEP, ERR_MIN, $urandom);
        send_word(FUNC_STEP, 17'sd12345, $urandom);

        // ki zero clears, proportional product wraps, output limits inverted
        drain();
        program_regs(GAIN_MIN, '0, GAIN_MAX, 32'sd100, -32'sd100,
                     -16'sd100, 16'sd100, 5'd31);
        send_word(FUNC_STEP, ERR_MIN, $urandom);
        send_word(FUNC_STEP, ERR_MAX, $urandom);
        send_word(FUNC_PRESET, ERR_MAX, 32'sd5);
        send_word(FUNC_STEP, '0, $urandom);

        // integral limits inverted
        drain();
        program_regs(16'sd1, GAIN_MIN, 16'sd1, -32'sd1000, 32'sd1000,
                     16'sd500, -16'sd500, 5'd31);
        send_word(FUNC_STEP, 17'sd3, $urandom);
        send_word(FUNC_STEP, -17'sd3, $urandom);
        send_word(FUNC_STEP, ERR_MAX, $urandom);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            random_settings(ph % 2 == 0);
            tx_gaps = (ph != 2);
            rx_gaps = (ph != 2);
            run_phase(105, (ph == 5) ? 50 : -1, (ph == 3) ? 20 : -1);
        end

        drain();
        if (mismatches == 0 && pending_results == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pibc_pkg.sv
rtl/core/pibc_mul.sv
rtl/core/pi_regulator_back_calc.sv
rtl/core/pibc_checker.sv
dv/pibc_tb_pkg.sv
dv/pibc_checker.sv
dv/testbench.sv
